// ===== hdl/dts_pkg.sv =====
package dts_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int TAG_BITS_DEF  = 16;
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 3;
    localparam int COUNT_W       = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SCHEDULE = 2'd0,
        ACT_DELIVER  = 2'd1,
        ACT_PURGE    = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_ACCEPTED    = 3'd0,
        RES_FULL        = 3'd1,
        RES_DELIVERED   = 3'd2,
        RES_NOTHING_DUE = 3'd3,
        RES_PURGED      = 3'd4
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_in;
        logic    sched_write;
        logic    purge;
        logic    clear_fired;
        logic    scan_start;
        logic    scan_compact;
        logic    latch_n;
        logic    emit;
        result_t emit_code;
        logic    div_start;
        logic    div_sum;
        logic    write_deadline;
        logic    next_fire;
        logic    end_compact;
    } dts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                full;
        logic                scan_busy;
        logic                none_due;
        logic                periodic;
        logic                final_fire;
        logic                div_busy;
        logic                out_free;
    } dts_stat_t;

endpackage

// ===== hdl/dts_if.sv =====
interface dts_in_if #(
    parameter int TAG_BITS  = dts_pkg::TAG_BITS_DEF,
    parameter int TIME_BITS = dts_pkg::TIME_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [dts_pkg::ACTION_W-1:0] action;
    logic [TAG_BITS-1:0]          item_tag;
    logic [TIME_BITS-1:0]         due_time;
    logic [TIME_BITS-1:0]         repeat_period;
    logic [TIME_BITS-1:0]         current_time;

    modport source (
        output valid, action, item_tag, due_time, repeat_period, current_time,
        input  ready
    );
    modport sink (
        input  valid, action, item_tag, due_time, repeat_period, current_time,
        output ready
    );
endinterface

interface dts_out_if #(
    parameter int TAG_BITS  = dts_pkg::TAG_BITS_DEF,
    parameter int TIME_BITS = dts_pkg::TIME_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [dts_pkg::STATUS_W-1:0] status;
    logic [TAG_BITS-1:0]          fired_tag;
    logic [TIME_BITS-1:0]         fired_deadline;
    logic [dts_pkg::COUNT_W-1:0]  due_count;
    logic                         last;

    modport source (
        output valid, status, fired_tag, fired_deadline, due_count, last,
        input  ready
    );
    modport sink (
        input  valid, status, fired_tag, fired_deadline, due_count, last,
        output ready
    );
endinterface

// ===== hdl/dts_ram.sv =====
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/dts_ctrl.sv =====
module dts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dts_pkg::dts_stat_t stat,
    output dts_pkg::dts_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCHED,
        S_PURGE,
        S_COUNT,
        S_CHECK,
        S_SELECT,
        S_EMIT,
        S_DIV,
        S_WB,
        S_NEXT,
        S_COMPACT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    unique case (stat.action)
                        dts_pkg::ACT_SCHEDULE: state_next = S_SCHED;
                        dts_pkg::ACT_DELIVER:
                        begin
                            cmd.clear_fired = 1'b1;
                            cmd.scan_start  = 1'b1;
                            state_next      = S_COUNT;
                        end
                        dts_pkg::ACT_PURGE:    state_next = S_PURGE;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_SCHED:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.full)
                    begin
                        cmd.emit_code = dts_pkg::RES_FULL;
                    end
                    else
                    begin
                        cmd.emit_code   = dts_pkg::RES_ACCEPTED;
                        cmd.sched_write = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_PURGE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_code = dts_pkg::RES_PURGED;
                    cmd.purge     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_COUNT:
            begin
                if (!stat.scan_busy)
                begin
                    cmd.latch_n = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.none_due)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_code = dts_pkg::RES_NOTHING_DUE;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SELECT;
                end
            end
            S_SELECT:
            begin
                if (!stat.scan_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_code = dts_pkg::RES_DELIVERED;
                    if (stat.periodic)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.div_sum = 1'b1;
                    state_next  = S_WB;
                end
            end
            S_WB:
            begin
                cmd.write_deadline = 1'b1;
                state_next         = S_NEXT;
            end
            S_NEXT:
            begin
                cmd.next_fire  = 1'b1;
                cmd.scan_start = 1'b1;
                if (stat.final_fire)
                begin
                    cmd.scan_compact = 1'b1;
                    state_next       = S_COMPACT;
                end
                else
                begin
                    state_next = S_SELECT;
                end
            end
            S_COMPACT:
            begin
                if (!stat.scan_busy)
                begin
                    cmd.end_compact = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hdl/dts_datapath.sv =====
module dts_datapath #(
    parameter int CAPACITY  = dts_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = dts_pkg::TIME_BITS_DEF,
    parameter int TAG_BITS  = dts_pkg::TAG_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dts_pkg::dts_cmd_t            cmd,
    output dts_pkg::dts_stat_t           stat,
    input  logic [dts_pkg::ACTION_W-1:0] in_action,
    input  logic [TAG_BITS-1:0]          in_tag,
    input  logic [TIME_BITS-1:0]         in_due,
    input  logic [TIME_BITS-1:0]         in_period,
    input  logic [TIME_BITS-1:0]         in_now,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dts_pkg::STATUS_W-1:0] out_status,
    output logic [TAG_BITS-1:0]          out_tag,
    output logic [TIME_BITS-1:0]         out_deadline,
    output logic [dts_pkg::COUNT_W-1:0]  out_count,
    output logic                         out_last
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = TAG_BITS + 2 * TIME_BITS;
    localparam int DIV_W   = $clog2(TIME_BITS + 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // Latched input
    logic [TAG_BITS-1:0]  tag_in_reg;
    logic [TIME_BITS-1:0] due_in_reg;
    logic [TIME_BITS-1:0] per_in_reg;
    logic [TIME_BITS-1:0] now_reg;

    // Table bookkeeping
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [CNT_W-1:0]    due_tot_reg;
    logic [CNT_W-1:0]    w_reg;
    logic [CAPACITY-1:0] fired_reg;

    // Scan
    logic [CNT_W-1:0] scan_idx_reg;
    logic             scan_busy_reg;
    logic             compact_reg;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // Earliest unfired due entry
    logic                 best_valid_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TAG_BITS-1:0]  best_tag_reg;
    logic [TIME_BITS-1:0] best_dl_reg;
    logic [TIME_BITS-1:0] best_per_reg;

    // Remainder unit
    logic [DIV_W-1:0]     div_cnt_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic [TIME_BITS-1:0] dvd_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [TIME_BITS-1:0] rem_next;
    logic [TIME_BITS:0]   rem_shift;
    logic [TIME_BITS:0]   rem_diff;
    logic [TIME_BITS:0]   sum_reg;

    // Output register
    logic                         out_valid_reg;
    logic [dts_pkg::STATUS_W-1:0] out_status_reg;
    logic [TAG_BITS-1:0]          out_tag_reg;
    logic [TIME_BITS-1:0]         out_dl_reg;
    logic [dts_pkg::COUNT_W-1:0]  out_count_reg;
    logic                         out_last_reg;

    // Memory
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [TIME_BITS-1:0] rd_dl;
    logic [TIME_BITS-1:0] rd_per;
    logic                 rd_due;
    logic                 rd_keep;
    logic                 rd_better;
    logic [TIME_BITS-1:0] headroom;
    logic [TIME_BITS-1:0] new_dl;
    logic                 emit_fire;

    dts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_tag    = ram_rdata[ENTRY_W-1 -: TAG_BITS];
    assign rd_dl     = ram_rdata[2*TIME_BITS-1 -: TIME_BITS];
    assign rd_per    = ram_rdata[TIME_BITS-1:0];
    assign rd_due    = (rd_dl <= now_reg);
    assign rd_keep   = !((rd_per == '0) && rd_due);
    assign rd_better = rd_due && !fired_reg[rd_idx_reg]
                       && (!best_valid_reg || (rd_dl < best_dl_reg));
    assign emit_fire = cmd.emit && (cmd.emit_code == dts_pkg::RES_DELIVERED);

    // New deadline: d + (q+1)*p, where (q+1)*p = elapsed - rem + p.
    assign headroom = TIME_MAX - best_dl_reg;
    assign new_dl   = (sum_reg > {1'b0, headroom}) ? TIME_MAX
                    : best_dl_reg + sum_reg[TIME_BITS-1:0];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_W-1:0];
        ram_wdata = {tag_in_reg, due_in_reg, per_in_reg};
        priority if (cmd.sched_write)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.write_deadline)
        begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_reg;
            ram_wdata = {best_tag_reg, new_dl, best_per_reg};
        end
        else if (compact_reg && rd_pend_reg && rd_keep)
        begin
            ram_we    = 1'b1;
            ram_waddr = w_reg[IDX_W-1:0];
            ram_wdata = ram_rdata;
        end
    end

    assign rem_shift = {rem_reg, dvd_reg[TIME_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, best_per_reg};
    assign rem_next  = (rem_shift >= {1'b0, best_per_reg}) ? rem_diff[TIME_BITS-1:0]
                     : rem_shift[TIME_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            due_tot_reg    <= '0;
            w_reg          <= '0;
            fired_reg      <= '0;
            scan_idx_reg   <= '0;
            scan_busy_reg  <= 1'b0;
            compact_reg    <= 1'b0;
            rd_pend_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.sched_write)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.purge)
            begin
                count_reg <= '0;
            end
            else if (cmd.end_compact)
            begin
                count_reg <= w_reg;
            end

            if (cmd.clear_fired)
            begin
                fired_reg <= '0;
            end
            else if (emit_fire)
            begin
                fired_reg[best_idx_reg] <= 1'b1;
            end

            if (cmd.latch_n)
            begin
                n_reg <= due_tot_reg;
                k_reg <= '0;
            end
            else if (cmd.next_fire)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end

            if (cmd.scan_start)
            begin
                scan_idx_reg   <= '0;
                scan_busy_reg  <= 1'b1;
                compact_reg    <= cmd.scan_compact;
                rd_pend_reg    <= 1'b0;
                best_valid_reg <= 1'b0;
                due_tot_reg    <= '0;
                w_reg          <= '0;
            end
            else if (scan_busy_reg)
            begin
                if (scan_idx_reg < count_reg)
                begin
                    rd_pend_reg  <= 1'b1;
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                else
                begin
                    rd_pend_reg <= 1'b0;
                    if (!rd_pend_reg)
                    begin
                        scan_busy_reg <= 1'b0;
                    end
                end
                if (rd_pend_reg)
                begin
                    if (rd_due)
                    begin
                        due_tot_reg <= due_tot_reg + CNT_W'(1);
                    end
                    if (rd_better)
                    begin
                        best_valid_reg <= 1'b1;
                    end
                    if (compact_reg && rd_keep)
                    begin
                        w_reg <= w_reg + CNT_W'(1);
                    end
                end
            end

            if (cmd.div_start)
            begin
                div_cnt_reg <= DIV_W'(TIME_BITS);
            end
            else if (div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - DIV_W'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            tag_in_reg <= in_tag;
            due_in_reg <= in_due;
            per_in_reg <= in_period;
            now_reg    <= in_now;
        end

        if (scan_busy_reg && (scan_idx_reg < count_reg))
        begin
            rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end

        if (scan_busy_reg && rd_pend_reg && rd_better)
        begin
            best_idx_reg <= rd_idx_reg;
            best_tag_reg <= rd_tag;
            best_dl_reg  <= rd_dl;
            best_per_reg <= rd_per;
        end

        if (cmd.div_start)
        begin
            elapsed_reg <= now_reg - best_dl_reg;
            dvd_reg     <= now_reg - best_dl_reg;
            rem_reg     <= '0;
        end
        else if (div_cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[TIME_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end

        if (cmd.div_sum)
        begin
            sum_reg <= {1'b0, elapsed_reg - rem_reg} + {1'b0, best_per_reg};
        end

        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_code;
            if (emit_fire)
            begin
                out_tag_reg   <= best_tag_reg;
                out_dl_reg    <= best_dl_reg;
                out_count_reg <= dts_pkg::COUNT_W'(n_reg);
                out_last_reg  <= (k_reg + CNT_W'(1) == n_reg);
            end
            else
            begin
                out_tag_reg   <= '0;
                out_dl_reg    <= '0;
                out_count_reg <= '0;
                out_last_reg  <= 1'b1;
            end
        end
    end

    assign stat.action     = in_action;
    assign stat.full       = (count_reg == CNT_W'(CAPACITY));
    assign stat.scan_busy  = scan_busy_reg;
    assign stat.none_due   = (n_reg == '0);
    assign stat.periodic   = (best_per_reg != '0);
    assign stat.final_fire = (k_reg + CNT_W'(1) == n_reg);
    assign stat.div_busy   = (div_cnt_reg != '0);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_tag      = out_tag_reg;
    assign out_deadline = out_dl_reg;
    assign out_count    = out_count_reg;
    assign out_last     = out_last_reg;

endmodule

// ===== hdl/deadline_timer_scheduler_core.sv =====
// Deadline timer scheduler: a table of up to CAPACITY timers (tag, absolute deadline,
// period; period zero is one-shot) held in a single read/write RAM. Schedule appends at
// the end of the table or answers table full; purge empties it; both answer with one
// transaction. Deliver emits every entry whose deadline is not after current_time,
// earliest first and ties in table order, with last on the final transaction, or a
// single nothing-due transaction. Each fired periodic entry moves to its first deadline
// after current_time, saturating at the largest time. Fired one-shots are then removed
// and the table is compacted in order. Deliver time is set by table scans through the
// one RAM read port and by the bit-serial remainder unit. One item is worked on at a
// time; a finished transaction waits in the output register while the next input may
// already be accepted.
module deadline_timer_scheduler_core #(
    parameter int CAPACITY  = dts_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = dts_pkg::TIME_BITS_DEF,
    parameter int TAG_BITS  = dts_pkg::TAG_BITS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    dts_in_if.sink   in_ch,
    dts_out_if.source out_ch
);

    dts_pkg::dts_cmd_t  cmd;
    dts_pkg::dts_stat_t stat;

    // Sequencer: walks each action through scans, emits and updates.
    dts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table RAM, scan and selection, remainder unit, output register.
    dts_datapath #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_action    (in_ch.action),
        .in_tag       (in_ch.item_tag),
        .in_due       (in_ch.due_time),
        .in_period    (in_ch.repeat_period),
        .in_now       (in_ch.current_time),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_status   (out_ch.status),
        .out_tag      (out_ch.fired_tag),
        .out_deadline (out_ch.fired_deadline),
        .out_count    (out_ch.due_count),
        .out_last     (out_ch.last)
    );

endmodule
